/* rtl/assert_macros.svh */
// Assertion macros used by the moving average core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Check that cond implies nxt on the following edge.
`define ASSERT_NEXT(lbl, clk, rstn, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, cond, nxt)
`endif
`endif

/* rtl/rbma_pkg.sv */
// Types and constants of the moving average block.
package rbma_pkg;

  localparam int SAMPLE_W          = 32;
  localparam int COUNT_W           = 8;
  localparam int SUM_W             = 40;
  localparam int MAX_WINDOW_DEF    = 128;
  localparam int DEFAULT_WINDOW_DEF = 24;
  localparam logic [COUNT_W-1:0] WINDOW_RESET = 8'd24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_NEG
  } rbma_state_t;

endpackage

/* rtl/rbma_ram.sv */
// Generic simple dual-port RAM with registered read.
module rbma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/ring_buffer_moving_average_core.sv */
// Moving average over a ring buffer of Q15.16 samples, top level.
//
// Input channel in_valid/in_ready carries one sample word; output channel
// out_valid/out_ready carries the mean of the stored samples and the number
// of samples now in the window. Every accepted word yields one result word.
// The accepting edge also reads the entry the word replaces. After it come
// the steps that drop that entry (only once the window is full), add the
// new word, take the magnitude, run 40 restoring division steps, and
// restore the sign and load the output. A new word is not taken while the
// last one is still in progress. All steps share one 41-bit add/subtract
// unit; in_ready is high only while the sequencer is idle. A finished
// result waits in the output register; if it is not yet taken when the
// next one is done, the sequencer holds the new result until the receiver
// takes the old one.
// cfg_we writes the window register and clears position, count and sum.
// A window of 0 or above MAX_WINDOW falls back to the default window.
// Reset (rst_n low, synchronous) clears the control state and sets the
// window to 24. The ring needs no clearing: a read entry is used only once
// the window is full, and by then it has been written.
`include "assert_macros.svh"

module ring_buffer_moving_average_core #(
  parameter int MAX_WINDOW     = rbma_pkg::MAX_WINDOW_DEF,
  parameter int DEFAULT_WINDOW = rbma_pkg::DEFAULT_WINDOW_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic        [rbma_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rbma_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rbma_pkg::SAMPLE_W-1:0] out_average,
  output logic        [rbma_pkg::COUNT_W-1:0]  out_filled_count
);

  import rbma_pkg::*;

  localparam int PW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEF_EFF = (DEFAULT_WINDOW > MAX_WINDOW) ? MAX_WINDOW : DEFAULT_WINDOW;
  localparam int ADD_W  = SUM_W + 1;
  localparam int DIV_CW = $clog2(SUM_W);

  rbma_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]  win_r;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] sample_r;
  logic [PW-1:0]       cur_pos_r;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic [DIV_CW-1:0]   div_cnt_r, div_cnt_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_average_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic [COUNT_W-1:0]  w_eff;
  logic [PW-1:0]       pos_eff;
  logic [COUNT_W:0]    pos_inc;
  logic                accept, full, load_out;
  logic [SAMPLE_W-1:0] old_sample;
  logic [COUNT_W:0]    trial;

  // shared add/subtract unit
  logic [ADD_W-1:0] add_a, add_b, add_res;
  logic             add_sub;

  assign add_res = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);

  assign w_eff = (win_r == '0 || win_r > COUNT_W'(MAX_WINDOW)) ? COUNT_W'(DEF_EFF) : win_r;
  assign pos_eff = (COUNT_W'(pos_r) >= w_eff) ? '0 : pos_r;
  assign pos_inc = (COUNT_W + 1)'(pos_eff) + 1'b1;
  assign full    = (cnt_r >= w_eff);
  assign accept  = in_valid && in_ready;
  assign trial   = {rem_r, acc_r[SUM_W-1]};

  rbma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW),
    .AW    (PW)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == ST_ADD),
    .waddr (cur_pos_r),
    .wdata (sample_r),
    .re    (accept),
    .raddr (pos_eff),
    .rdata (old_sample)
  );

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    acc_nxt     = acc_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    neg_nxt     = neg_r;
    add_a       = '0;
    add_b       = '0;
    add_sub     = 1'b0;
    load_out    = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pos_nxt   = (pos_inc >= (COUNT_W + 1)'(w_eff)) ? '0 : pos_inc[PW-1:0];
          cnt_nxt   = full ? w_eff : cnt_r + 1'b1;
          state_nxt = full ? ST_SUB : ST_ADD;
        end
      end
      ST_SUB: begin
        // drop the entry being overwritten
        add_a     = {sum_r[SUM_W-1], sum_r};
        add_b     = ADD_W'(signed'(old_sample));
        add_sub   = 1'b1;
        sum_nxt   = add_res[SUM_W-1:0];
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        add_a     = {sum_r[SUM_W-1], sum_r};
        add_b     = ADD_W'(signed'(sample_r));
        sum_nxt   = add_res[SUM_W-1:0];
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        add_b       = {sum_r[SUM_W-1], sum_r};
        add_sub     = 1'b1;
        neg_nxt     = sum_r[SUM_W-1];
        acc_nxt     = sum_r[SUM_W-1] ? add_res[SUM_W-1:0] : sum_r;
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: shift in one dividend bit, try subtracting the count
        add_a   = ADD_W'(trial);
        add_b   = ADD_W'(cnt_r);
        add_sub = 1'b1;
        if (add_res[ADD_W-1]) begin
          rem_nxt = trial[COUNT_W-1:0];
          acc_nxt = {acc_r[SUM_W-2:0], 1'b0};
        end else begin
          rem_nxt = add_res[COUNT_W-1:0];
          acc_nxt = {acc_r[SUM_W-2:0], 1'b1};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CW'(SUM_W - 1)) begin
          state_nxt = ST_NEG;
        end
      end
      ST_NEG: begin
        add_b   = {1'b0, acc_r};
        add_sub = 1'b1;
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= WINDOW_RESET;
      pos_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        win_r <= cfg_wdata;
        pos_r <= '0;
        cnt_r <= '0;
        sum_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r  <= in_sample;
      cur_pos_r <= pos_eff;
    end
    acc_r     <= acc_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    neg_r     <= neg_nxt;
    if (load_out) begin
      out_average_r <= neg_r ? add_res[SAMPLE_W-1:0] : acc_r[SAMPLE_W-1:0];
      out_count_r   <= cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_average      = out_average_r;
  assign out_filled_count = out_count_r;

  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, !in_ready)
  `ASSERT_CLK(a_count_in_window, clk, rst_n, cnt_r <= w_eff)
  `ASSERT_CLK(a_pos_in_window, clk, rst_n, COUNT_W'(pos_r) < w_eff)
  `ASSERT_NEXT(a_hold_result, clk, rst_n,
               state_r == ST_NEG && out_valid_r && !out_ready, state_r == ST_NEG)

endmodule

/* dv/rbma_mean_checker.sv */
// Checker for the moving average block: predicts each mean and compares it.
module rbma_mean_checker
  import rbma_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic        [COUNT_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [SAMPLE_W-1:0]  out_average,
  input  logic        [COUNT_W-1:0]   out_filled_count,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic        [COUNT_W-1:0]  filled;
  } mean_word_t;

  logic signed [SAMPLE_W-1:0] sample_hist [MAX_WINDOW_DEF];
  logic        [6:0]          head_pos;
  logic        [COUNT_W-1:0]  filled_cnt;
  longint                     window_sum;
  logic        [COUNT_W-1:0]  window_reg;
  mean_word_t                 mean_expected_q[$];

  function automatic int unsigned window_len(input logic [COUNT_W-1:0] w);
    if (w == 0 || w > MAX_WINDOW_DEF) begin
      return DEFAULT_WINDOW_DEF;
    end
    return w;
  endfunction

  // Store the sample, update the running sum and return the new mean.
  function automatic mean_word_t predict_mean(input logic signed [SAMPLE_W-1:0] s);
    int unsigned w;
    int unsigned pos;
    longint      cnt;
    longint      quo;
    mean_word_t  r;
    w   = window_len(window_reg);
    pos = head_pos;
    if (pos >= w) pos = 0;
    if (filled_cnt >= w) begin
      // window full: drop the oldest sample
      window_sum = window_sum - longint'(sample_hist[pos]);
      filled_cnt = COUNT_W'(w);
    end else begin
      filled_cnt = filled_cnt + 1'b1;
    end
    sample_hist[pos] = s;
    window_sum = window_sum + longint'(s);
    pos = pos + 1;
    if (pos >= w) pos = 0;
    head_pos = 7'(pos);
    cnt = filled_cnt;
    quo = (cnt == 0) ? 0 : window_sum / cnt;
    r.average = quo[SAMPLE_W-1:0];
    r.filled  = filled_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    mean_word_t want;
    if (!rst_n) begin
      head_pos   = '0;
      filled_cnt = '0;
      window_sum = 0;
      window_reg = WINDOW_RESET;
      mean_expected_q.delete();
    end else begin
      if (cfg_we) begin
        window_reg = cfg_wdata;
        head_pos   = '0;
        filled_cnt = '0;
        window_sum = 0;
      end
      if (in_valid && in_ready) begin
        mean_expected_q.push_back(predict_mean(in_sample));
      end
      if (out_valid && out_ready) begin
        if (mean_expected_q.size() == 0) begin
          $display("%0t: unexpected result word: average %0d, count %0d",
                   $time, out_average, out_filled_count);
          fail_count = fail_count + 1;
        end else begin
          want = mean_expected_q.pop_front();
          if (out_average !== want.average) begin
            $display("%0t: average mismatch: expected %0d, got %0d",
                     $time, want.average, out_average);
            fail_count = fail_count + 1;
          end
          if (out_filled_count !== want.filled) begin
            $display("%0t: filled_count mismatch: expected %0d, got %0d",
                     $time, want.filled, out_filled_count);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = mean_expected_q.size();
  end

endmodule

/* dv/tb_ring_buffer_moving_average_core.sv */
// Testbench top for the moving average block: stimulus, handshake idling and verdict.
module tb_ring_buffer_moving_average_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rbma_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 12;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic        [COUNT_W-1:0]  cfg_wdata;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;
  logic        [COUNT_W-1:0]  out_filled_count;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_tgl = 1'b0;
  logic hold_seen = 1'b0;
  int hold_cnt = 0;

  int unsigned phase_window[NUM_PHASES] = '{1, 0, 255, 128, 129, 127, 2, 5, 3, 200, 0, 64};
  int unsigned phase_items[NUM_PHASES]  = '{100, 100, 100, 260, 100, 260, 100, 100, 100,
                                            100, 100, 200};

  always #5 clk = ~clk;

  ring_buffer_moving_average_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average      (out_average),
    .out_filled_count (out_filled_count)
  );

  rbma_mean_checker u_mean_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average      (out_average),
    .out_filled_count (out_filled_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_cnt  <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one sample word after a random gap; return at the negedge after acceptance.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain all results, let the sequencer settle, then write the window.
  task automatic write_window(input logic [COUNT_W-1:0] w);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
      default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
    endcase
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0, 1: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      2, 3, 4: return $urandom_range(2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_sample = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset window: extremes of the sample range.
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h8000_0000);
    send_sample(32'h0000_0000);
    send_sample(-32'sd1);
    send_sample(32'sd1);

    // Small window: truncation toward zero, wrap and full-window replacement.
    write_window(8'd3);
    send_sample(-32'sd3);
    send_sample(32'sd0);
    send_sample(32'sd0);
    repeat (3) send_sample(32'h7FFF_FFFF);
    repeat (3) send_sample(32'h8000_0000);

    // Single-entry window: the mean is the sample itself.
    write_window(8'd1);
    send_sample(-32'sd1);
    send_sample(32'h8000_0000);
    send_sample(32'sd5);

    phase_window[10] = $urandom_range(255);
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_window(COUNT_W'(phase_window[p]));
      set_idling(p % 4);
      // hold the receiver off while the sender keeps offering words
      if (p == 4) hold_tgl = ~hold_tgl;
      for (int i = 0; i < phase_items[p]; i++) begin
        send_sample(rand_sample());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("ring_buffer_moving_average_core regression: pass");
    end else begin
      $display("ring_buffer_moving_average_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("ring_buffer_moving_average_core regression: fail");
    $finish;
  end

endmodule
